// ----- src/vertex_transform_4x4_assert.svh -----
// Assertion macros for the vertex transform block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define VT4_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vt4 check failed");

// Next-cycle implication, disabled while in reset.
`define VT4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vt4 check failed");

`endif

// ----- src/vt4_pkg.sv -----
// Package for the vertex transform block: payload structs, lane result
// struct and matrix register constants. No dependencies.
`default_nettype none

package vt4_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned LANE_LAT  = 4;

  // identity matrix, two Q16.16 entries per register
  localparam logic [NUM_REGS-1:0][REG_W-1:0] REG_RESET = '{
    64'h0001_0000_0000_0000,  // row3_cols23
    64'h0000_0000_0000_0000,  // row3_cols01
    64'h0000_0000_0001_0000,  // row2_cols23
    64'h0000_0000_0000_0000,  // row2_cols01
    64'h0000_0000_0000_0000,  // row1_cols23
    64'h0001_0000_0000_0000,  // row1_cols01
    64'h0000_0000_0000_0000,  // row0_cols23
    64'h0000_0000_0001_0000   // row0_cols01
  };

  typedef struct packed {
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_z;
    logic signed [FIELD_W-1:0] vec_w;
  } vec_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] res_x;
    logic signed [FIELD_W-1:0] res_y;
    logic signed [FIELD_W-1:0] res_z;
    logic signed [FIELD_W-1:0] res_w;
    logic                      saturated;
  } vec_out_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] val;
    logic                      clip;
  } lane_out_t;

endpackage

`default_nettype wire

// ----- src/vt4_matrix_regs.sv -----
// Matrix configuration registers with identity reset.
// Depends on vt4_pkg.
`default_nettype none

module vt4_matrix_regs (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_valid_i,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [vt4_pkg::REG_W-1:0]                     cfg_data_i,
  output logic [vt4_pkg::NUM_REGS-1:0][vt4_pkg::REG_W-1:0] mat_o
);
  import vt4_pkg::*;

  logic [NUM_REGS-1:0][REG_W-1:0] mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= REG_RESET;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      mat_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  assign mat_o = mat_q;

endmodule

`default_nettype wire

// ----- src/vt4_lane.sv -----
// One output column: four multipliers, two-level adder, shift and saturate.
// Depends on vt4_pkg. Registers prod_q, pair_q, sum_q and out_q; one item per cycle.
`default_nettype none

module vt4_lane #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic [3:0][COMPONENT_WIDTH-1:0]        vec_i,
  input  logic [3:0][COMPONENT_WIDTH-1:0]        col_i,
  output vt4_pkg::lane_out_t                     out_o
);
  import vt4_pkg::*;

  localparam int unsigned PW   = 2 * COMPONENT_WIDTH;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned HIW  = SUMW - COMPONENT_WIDTH + 1;
  localparam logic [63:0] CMAX64 = (64'd1 << (COMPONENT_WIDTH - 1)) - 64'd1;
  localparam logic [FIELD_W-1:0] CMAX = CMAX64[FIELD_W-1:0];
  localparam logic [FIELD_W-1:0] CMIN = ~CMAX;

  logic signed [PW-1:0]   prod_q [4];
  logic signed [SUMW-1:0] pair_q [2];
  logic signed [SUMW-1:0] sum_q;
  lane_out_t              out_q;

  logic signed [SUMW-1:0]            shifted;
  logic [HIW-1:0]                    hi_bits;
  logic signed [COMPONENT_WIDTH-1:0] low_val;
  logic                              fits;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      prod_q[k] <= $signed(vec_i[k]) * $signed(col_i[k]);
    end
    pair_q[0] <= SUMW'(prod_q[0]) + SUMW'(prod_q[1]);
    pair_q[1] <= SUMW'(prod_q[2]) + SUMW'(prod_q[3]);
    sum_q     <= pair_q[0] + pair_q[1];
  end

  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    hi_bits = shifted[SUMW-1:COMPONENT_WIDTH-1];
    low_val = shifted[COMPONENT_WIDTH-1:0];
    fits    = (&hi_bits) || !(|hi_bits);
  end

  always_ff @(posedge clk_i) begin
    out_q.clip <= !fits;
    if (fits) begin
      out_q.val <= FIELD_W'(low_val);
    end else if (shifted[SUMW-1]) begin
      out_q.val <= CMIN;
    end else begin
      out_q.val <= CMAX;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ----- src/vt4_merge.sv -----
// Merge stage: packs lane results into the output struct and ORs clip flags.
// Depends on vt4_pkg.
`default_nettype none

module vt4_merge (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  input  vt4_pkg::lane_out_t [vt4_pkg::NUM_LANES-1:0]  lanes_i,
  output logic                                         valid_o,
  output vt4_pkg::vec_out_t                            res_o
);
  import vt4_pkg::*;

  logic     valid_q;
  vec_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.res_x     <= lanes_i[0].val;
    res_q.res_y     <= lanes_i[1].val;
    res_q.res_z     <= lanes_i[2].val;
    res_q.res_w     <= lanes_i[3].val;
    res_q.saturated <= lanes_i[0].clip | lanes_i[1].clip |
                       lanes_i[2].clip | lanes_i[3].clip;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ----- src/vertex_transform_4x4.sv -----
// Top level: 4x4 matrix times homogeneous row vector, Q16.16, saturating.
// Depends on vt4_pkg, vt4_matrix_regs, vt4_lane, vt4_merge.
//
//   channel  | signals                                    | direction
//   ---------+--------------------------------------------+----------
//   command  | start, busy, vec_i                         | in
//   result   | res_valid_o, res_o                         | out
//   config   | cfg_valid_i, cfg_ready_o, cfg_index_i,     | in
//            | cfg_data_i                                 |
//
// One transaction per cycle; busy stays low, the four column lanes are
// fully pipelined. Each result passes through the 4 lane stages and the
// merge register and is strobed by res_valid_o for one cycle.
// Reset loads the identity matrix and empties the pipeline.
// Matrix writes are taken every cycle; index 8 and above are ignored.
`default_nettype none

module vertex_transform_4x4 #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  vt4_pkg::vec_in_t                 vec_i,
  output logic                             res_valid_o,
  output vt4_pkg::vec_out_t                res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vt4_pkg::REG_W-1:0]        cfg_data_i
);
  import vt4_pkg::*;

  logic [NUM_REGS-1:0][REG_W-1:0]               mat;
  logic [3:0][COMPONENT_WIDTH-1:0]              vec_c;
  logic [NUM_LANES-1:0][3:0][COMPONENT_WIDTH-1:0] col_c;
  lane_out_t [NUM_LANES-1:0]                    lane_out;
  logic [LANE_LAT-1:0]                          vld_q;
  logic                                         accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  vt4_matrix_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mat_o       (mat)
  );

  assign vec_c[0] = vec_i.vec_x[COMPONENT_WIDTH-1:0];
  assign vec_c[1] = vec_i.vec_y[COMPONENT_WIDTH-1:0];
  assign vec_c[2] = vec_i.vec_z[COMPONENT_WIDTH-1:0];
  assign vec_c[3] = vec_i.vec_w[COMPONENT_WIDTH-1:0];

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
    for (genvar i = 0; i < 4; i++) begin : g_row
      assign col_c[j][i] = mat[i*2 + j/2][FIELD_W*(j%2) +: COMPONENT_WIDTH];
    end

    vt4_lane #(
      .FRAC_BITS       (FRAC_BITS),
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_lane (
      .clk_i (clk_i),
      .vec_i (vec_c),
      .col_i (col_c[j]),
      .out_o (lane_out[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LANE_LAT-2:0], accept};
    end
  end

  vt4_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[LANE_LAT-1]),
    .lanes_i (lane_out),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

// ----- src/vt4_checker.sv -----
// Port-level checker for vertex_transform_4x4, bound to the top level.
// Depends on vt4_pkg and vertex_transform_4x4_assert.svh.
`default_nettype none

`include "vertex_transform_4x4_assert.svh"

module vt4_checker #(
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           res_valid_o,
  input vt4_pkg::vec_out_t              res_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o
);
  import vt4_pkg::*;

  localparam logic [63:0] CMAX64 = (64'd1 << (COMPONENT_WIDTH - 1)) - 64'd1;
  localparam logic [FIELD_W-1:0] CMAX = CMAX64[FIELD_W-1:0];
  localparam logic [FIELD_W-1:0] CMIN = ~CMAX;

  logic accept;
  logic sat_seen;

  assign accept = start && !busy;
  assign sat_seen = (res_o.res_x == CMAX) || (res_o.res_x == CMIN) ||
                    (res_o.res_y == CMAX) || (res_o.res_y == CMIN) ||
                    (res_o.res_z == CMAX) || (res_o.res_z == CMIN) ||
                    (res_o.res_w == CMAX) || (res_o.res_w == CMIN);

  `VT4_ASSERT_NOW(a_result_has_cause, res_valid_o, $past(accept, 5))
  `VT4_ASSERT_NOW(a_result_follows, accept, ##5 res_valid_o)
  `VT4_ASSERT_NOW(a_sat_at_limit, res_valid_o && res_o.saturated, sat_seen)
  `VT4_ASSERT_NEXT(a_cmd_no_stall, start || cfg_valid_i, !busy && cfg_ready_o)

endmodule

bind vertex_transform_4x4 vt4_checker #(
  .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_vt4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
